/* hdl/ddq_pkg.sv */
// shared types and codes for the ring-buffer deque
`default_nettype none

package ddq_pkg;

  // operation carried by each input item
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_PUSH_FRONT = 2'd0;
  localparam kind_t KIND_PUSH_BACK  = 2'd1;
  localparam kind_t KIND_POP_FRONT  = 2'd2;
  localparam kind_t KIND_DUMP       = 2'd3;

  // stored word
  typedef logic signed [31:0] word_t;

  // most results one dump item may produce
  localparam int unsigned MAX_RESULTS = 32;

endpackage

`default_nettype wire

/* hdl/ddq_ram.sv */
// generic single-port-write, registered-read RAM
`default_nettype none

module ddq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire [WIDTH-1:0]             wr_data,
  input  wire                         rd_en,
  input  wire [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [WIDTH-1:0]            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/double_ended_queue_ring.sv */
// top level of the ring-buffer deque: control, pointers and output register
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  in_      | input     | in_valid/in_stall  | in_kind, in_value
//  out_     | output    | out_valid/out_stall| out_data, out_data_valid, out_queue_empty,
//           |           |                    | out_overflow, out_last
//
// a push is answered straight from idle; a pop reads the RAM, then the read state registers the word.
// a dump of n words gives one word per cycle while out_stall allows, set by the single RAM read port.
// one item is worked on at a time; the next is taken once its last result is registered.
// reset clears pointers, count and output valid; the word store is not cleared.
// out_stall holds the output register and, through it, the input and the dump sweep.
`default_nettype none

module double_ended_queue_ring #(
  parameter int DEPTH = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  ddq_pkg::kind_t        in_kind,
  input  ddq_pkg::word_t        in_value,
  output logic                  out_valid,
  input  wire                   out_stall,
  output ddq_pkg::word_t        out_data,
  output logic                  out_data_valid,
  output logic                  out_queue_empty,
  output logic                  out_overflow,
  output logic                  out_last
);

  import ddq_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = AW + 1;
  localparam int CAP = (DEPTH < int'(MAX_RESULTS)) ? DEPTH : int'(MAX_RESULTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DUMP = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] left_r, left_nxt;

  logic          out_valid_r, out_valid_nxt;
  word_t         out_data_r, out_data_nxt;
  logic          out_dv_r, out_dv_nxt;
  logic          out_empty_r, out_empty_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          out_last_r, out_last_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  logic          out_free, in_acc, full, is_push;
  logic [AW-1:0] head_dec, head_inc, ptr_inc, tail;
  logic [CW-1:0] tail_sum, dump_n;

  // word store
  ddq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // handshake and ring arithmetic
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign is_push  = (in_kind inside {KIND_PUSH_FRONT, KIND_PUSH_BACK});

  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign ptr_inc  = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + AW'(1);
  assign tail_sum = {1'b0, head_r} + count_r;
  assign tail     = (tail_sum >= CW'(DEPTH)) ? AW'(tail_sum - CW'(DEPTH)) : tail_sum[AW-1:0];
  assign dump_n   = (count_r > CW'(CAP)) ? CW'(CAP) : count_r;

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    left_nxt      = left_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = head_dec;
    ram_raddr     = head_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_dv_nxt    = out_dv_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;

    // output register drains when taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_push) begin
            // push: write one entry unless full (then flag overflow), answer at once
            if (!full) begin
              ram_we    = 1'b1;
              count_nxt = count_r + CW'(1);
              if (in_kind == KIND_PUSH_FRONT) begin
                ram_waddr = head_dec;
                head_nxt  = head_dec;
              end else begin
                ram_waddr = tail;
              end
            end
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_dv_nxt    = 1'b0;
            out_empty_nxt = 1'b0;
            out_ovf_nxt   = full;
            out_last_nxt  = 1'b1;
          end else if (count_r == '0) begin
            // pop or dump of an empty queue
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            out_dv_nxt    = 1'b0;
            out_empty_nxt = 1'b1;
            out_ovf_nxt   = 1'b0;
            out_last_nxt  = 1'b1;
          end else if (in_kind == KIND_POP_FRONT) begin
            ram_re    = 1'b1;
            ram_raddr = head_r;
            head_nxt  = head_inc;
            count_nxt = count_r - CW'(1);
            state_nxt = ST_READ;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = head_r;
            ptr_nxt   = head_inc;
            left_nxt  = dump_n;
            state_nxt = ST_DUMP;
          end
        end
      end

      ST_READ: begin
        // popped word is waiting on the RAM output
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ram_rdata;
          out_dv_nxt    = 1'b1;
          out_empty_nxt = (count_r == '0);
          out_ovf_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_DUMP: begin
        // one word per cycle while the output is free, next read issued as the current one is taken
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ram_rdata;
          out_dv_nxt    = 1'b1;
          out_empty_nxt = 1'b0;
          out_ovf_nxt   = 1'b0;
          out_last_nxt  = (left_r == CW'(1));
          if (left_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_r;
            ptr_nxt   = ptr_inc;
            left_nxt  = left_r - CW'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    out_dv_r    <= out_dv_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign out_data_valid  = out_dv_r;
  assign out_queue_empty = out_empty_r;
  assign out_overflow    = out_ovf_r;
  assign out_last        = out_last_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP) |-> (count_r != '0 && left_r != '0))
    else $error("dump sweep running on an empty queue");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_dv_r) |-> (out_data_r == '0 && out_last_r))
    else $error("invalid result carries data or is not last");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_push && !full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("accepted push did not grow the queue");

  a_ovf_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (!out_dv_r && !out_empty_r))
    else $error("overflow result with data or empty flag");

endmodule

`default_nettype wire
